// ----- rtl/srr_pkg.sv -----
package srr_pkg;

   // field widths
   localparam int SEQ_W      = 10;
   localparam int ACK_W      = 16;
   localparam int CKS_W      = 32;
   localparam int WS_W       = 6;
   localparam int WSTART_W   = 11;
   localparam int ACKCK_W    = 13;
   localparam int WORD01_W   = 64;
   localparam int WORD2_W    = 32;
   localparam int PAY_BYTES  = 20;
   localparam int PAY_W      = 8 * PAY_BYTES;

   // sequence space and window
   localparam int SEQ_SPACE    = 1024;
   localparam int IDX_W        = $clog2(SEQ_SPACE);
   localparam int WINDOW_MAX   = 32;
   localparam int WINDOW_RESET = 8;
   localparam int WSTART_RESET = 1;

   // acknowledgement checksum offset for the fixed ack payload
   localparam int ACK_BASE = 3184;

   // checksum arithmetic
   localparam int BSUM_W  = 13;
   localparam int BASE_W  = 17;
   localparam int TOTAL_W = 18;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WREAD,
      ST_WEVAL,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                mark_wr;
      logic                pay_wr;
      logic [IDX_W-1:0]    wr_addr;
      logic                wr_mark;
   } store_cmd_type;

   typedef struct packed {
      logic                kind;
      logic [SEQ_W-1:0]    seq;
      logic [ACKCK_W-1:0]  ack_checksum;
      logic [WORD01_W-1:0] word0;
      logic [WORD01_W-1:0] word1;
      logic [WORD2_W-1:0]  word2;
   } result_type;

endpackage

// ----- rtl/srr_req_if.sv -----
interface srr_req_if;
   logic                               valid;
   logic                               ready;
   logic [srr_pkg::SEQ_W-1:0]          received_seq;
   logic [srr_pkg::ACK_W-1:0]          received_ack;
   logic signed [srr_pkg::CKS_W-1:0]   received_checksum;
   logic [srr_pkg::WORD01_W-1:0]       payload_word0;
   logic [srr_pkg::WORD01_W-1:0]       payload_word1;
   logic [srr_pkg::WORD2_W-1:0]        payload_word2;

   modport source (
      output valid, received_seq, received_ack, received_checksum,
             payload_word0, payload_word1, payload_word2,
      input  ready
   );

   modport sink (
      input  valid, received_seq, received_ack, received_checksum,
             payload_word0, payload_word1, payload_word2,
      output ready
   );
endinterface

// ----- rtl/srr_rsp_if.sv -----
interface srr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            result_kind;
   logic [srr_pkg::SEQ_W-1:0]       result_seq;
   logic [srr_pkg::ACKCK_W-1:0]     ack_checksum;
   logic [srr_pkg::WORD01_W-1:0]    out_word0;
   logic [srr_pkg::WORD01_W-1:0]    out_word1;
   logic [srr_pkg::WORD2_W-1:0]     out_word2;
   logic                            last_of_run;

   modport source (
      output valid, result_kind, result_seq, ack_checksum,
             out_word0, out_word1, out_word2, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, result_kind, result_seq, ack_checksum,
             out_word0, out_word1, out_word2, last_of_run,
      output ready
   );
endinterface

// ----- rtl/srr_csum.sv -----
module srr_csum (
   input  logic                              clock,
   input  logic                              load,
   input  logic [srr_pkg::SEQ_W-1:0]         seq,
   input  logic [srr_pkg::ACK_W-1:0]         ack,
   input  logic signed [srr_pkg::CKS_W-1:0]  checksum,
   input  logic [srr_pkg::PAY_W-1:0]         payload,
   output logic                              ok
);

   localparam int NB = srr_pkg::PAY_BYTES;

   logic [7:0]                         byte_v [NB];
   logic [8:0]                         l1 [NB/2];
   logic [9:0]                         l2 [NB/4];
   logic [srr_pkg::BSUM_W-1:0]         bsum;
   logic [srr_pkg::BSUM_W-1:0]         bsum_ff;
   logic [srr_pkg::BASE_W-1:0]         base_ff;
   logic [srr_pkg::CKS_W-1:0]          cks_ff;
   logic [srr_pkg::TOTAL_W-1:0]        total;

   // signed byte sum as a shallow tree
   always_comb begin
      for (int k = 0; k < NB; k++) begin
         byte_v[k] = payload[8*k +: 8];
      end
      for (int k = 0; k < NB/2; k++) begin
         l1[k] = {byte_v[2*k][7], byte_v[2*k]} + {byte_v[2*k+1][7], byte_v[2*k+1]};
      end
      for (int k = 0; k < NB/4; k++) begin
         l2[k] = {l1[2*k][8], l1[2*k]} + {l1[2*k+1][8], l1[2*k+1]};
      end
      bsum = '0;
      for (int k = 0; k < NB/4; k++) begin
         bsum = bsum + {{(srr_pkg::BSUM_W-10){l2[k][9]}}, l2[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bsum_ff <= bsum;
         base_ff <= {{(srr_pkg::BASE_W-srr_pkg::SEQ_W){1'b0}}, seq}
                  + {{(srr_pkg::BASE_W-srr_pkg::ACK_W){1'b0}}, ack};
         cks_ff  <= checksum;
      end
   end

   assign total = {{(srr_pkg::TOTAL_W-srr_pkg::BSUM_W){bsum_ff[srr_pkg::BSUM_W-1]}}, bsum_ff}
                + {{(srr_pkg::TOTAL_W-srr_pkg::BASE_W){1'b0}}, base_ff};

   // doubled total, sign-extended to the carried width
   assign ok = ({{(srr_pkg::CKS_W-srr_pkg::TOTAL_W-1){total[srr_pkg::TOTAL_W-1]}},
                 total, 1'b0} == cks_ff);

endmodule

// ----- rtl/srr_store.sv -----
module srr_store (
   input  logic                          clock,
   input  srr_pkg::store_cmd_type        cmd,
   input  logic [srr_pkg::PAY_W-1:0]     wr_payload,
   output logic                          rd_mark,
   output logic [srr_pkg::PAY_W-1:0]     rd_payload
);

   logic                          mark_mem [srr_pkg::SEQ_SPACE];
   logic [srr_pkg::PAY_W-1:0]     pay_mem  [srr_pkg::SEQ_SPACE];

   always_ff @(posedge clock) begin
      if (cmd.mark_wr) begin
         mark_mem[cmd.wr_addr] <= cmd.wr_mark;
      end
      if (cmd.pay_wr) begin
         pay_mem[cmd.wr_addr] <= wr_payload;
      end
      if (cmd.rd_en) begin
         rd_mark    <= mark_mem[cmd.rd_addr];
         rd_payload <= pay_mem[cmd.rd_addr];
      end
   end

endmodule

// ----- rtl/srr_ctrl.sv -----
module srr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   srr_req_if.sink                       req,
   srr_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [srr_pkg::WS_W-1:0]      csr_wr_data,
   input  logic                          cks_ok,
   input  logic                          rd_mark,
   input  logic [srr_pkg::PAY_W-1:0]     rd_payload,
   output logic                          csum_load,
   output srr_pkg::store_cmd_type        cmd,
   output logic [srr_pkg::PAY_W-1:0]     wr_payload
);

   localparam int W0 = srr_pkg::WORD01_W;
   localparam int W2 = srr_pkg::WORD2_W;

   srr_pkg::state_type               state_ff, state_in;
   logic [srr_pkg::WSTART_W-1:0]     wstart_ff, wstart_in;
   logic [srr_pkg::WSTART_W-1:0]     limit_ff, limit_in;
   logic [srr_pkg::WS_W-1:0]         ws_ff;
   logic [srr_pkg::IDX_W-1:0]        clr_ff, clr_in;
   logic [srr_pkg::SEQ_W-1:0]        seq_ff, seq_in;
   logic [srr_pkg::PAY_W-1:0]        pay_ff, pay_in;
   srr_pkg::result_type              pend_ff, pend_in;
   srr_pkg::result_type              out_ff, out_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_last_ff, out_last_in;

   logic                             slot_free;
   logic                             push;
   logic                             push_last;
   logic [srr_pkg::WS_W-1:0]         ws_sat;
   logic [srr_pkg::WSTART_W-1:0]     limit;
   logic [srr_pkg::WSTART_W-1:0]     seq_ext;
   logic                             in_window;
   srr_pkg::result_type              ack_res;
   srr_pkg::result_type              dlv_res;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign ws_sat    = (ws_ff > srr_pkg::WS_W'(srr_pkg::WINDOW_MAX))
                    ? srr_pkg::WS_W'(srr_pkg::WINDOW_MAX) : ws_ff;
   assign limit     = wstart_ff + {{(srr_pkg::WSTART_W-srr_pkg::WS_W){1'b0}}, ws_sat};
   assign seq_ext   = {{(srr_pkg::WSTART_W-srr_pkg::SEQ_W){1'b0}}, seq_ff};
   assign in_window = (seq_ext >= wstart_ff) && (seq_ext < limit);

   always_comb begin
      ack_res.kind         = srr_pkg::KIND_ACK;
      ack_res.seq          = seq_ff;
      ack_res.ack_checksum = srr_pkg::ACKCK_W'({1'b0, seq_ff, 2'b00})
                           + srr_pkg::ACKCK_W'(srr_pkg::ACK_BASE);
      ack_res.word0        = '0;
      ack_res.word1        = '0;
      ack_res.word2        = '0;

      dlv_res.kind         = srr_pkg::KIND_DELIVER;
      dlv_res.seq          = wstart_ff[srr_pkg::SEQ_W-1:0];
      dlv_res.ack_checksum = '0;
      dlv_res.word0        = rd_payload[W0-1:0];
      dlv_res.word1        = rd_payload[2*W0-1:W0];
      dlv_res.word2        = rd_payload[2*W0+W2-1:2*W0];
   end

   always_comb begin
      state_in    = state_ff;
      wstart_in   = wstart_ff;
      limit_in    = limit_ff;
      clr_in      = clr_ff;
      seq_in      = seq_ff;
      pay_in      = pay_ff;
      pend_in     = pend_ff;
      push        = 1'b0;
      push_last   = 1'b0;
      csum_load   = 1'b0;
      req.ready   = 1'b0;
      cmd         = '0;

      case (state_ff)
         srr_pkg::ST_CLEAR: begin
            cmd.mark_wr = 1'b1;
            cmd.wr_addr = clr_ff;
            cmd.wr_mark = 1'b0;
            clr_in      = clr_ff + srr_pkg::IDX_W'(1);
            if (clr_ff == srr_pkg::IDX_W'(srr_pkg::SEQ_SPACE - 1)) begin
               state_in = srr_pkg::ST_IDLE;
            end
         end
         srr_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               seq_in      = req.received_seq;
               pay_in      = {req.payload_word2, req.payload_word1, req.payload_word0};
               csum_load   = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = req.received_seq;
               state_in    = srr_pkg::ST_CHECK;
            end
         end
         srr_pkg::ST_CHECK: begin
            if (!cks_ok) begin
               state_in = srr_pkg::ST_IDLE;
            end else if (rd_mark) begin
               pend_in  = ack_res;
               state_in = srr_pkg::ST_FLUSH;
            end else if (!in_window) begin
               state_in = srr_pkg::ST_IDLE;
            end else begin
               cmd.mark_wr = 1'b1;
               cmd.pay_wr  = 1'b1;
               cmd.wr_addr = seq_ff;
               cmd.wr_mark = 1'b1;
               pend_in     = ack_res;
               limit_in    = limit;
               state_in    = srr_pkg::ST_WREAD;
            end
         end
         srr_pkg::ST_WREAD: begin
            if ((wstart_ff < limit_ff)
                && (wstart_ff < srr_pkg::WSTART_W'(srr_pkg::SEQ_SPACE))) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = wstart_ff[srr_pkg::IDX_W-1:0];
               state_in    = srr_pkg::ST_WEVAL;
            end else begin
               state_in = srr_pkg::ST_FLUSH;
            end
         end
         srr_pkg::ST_WEVAL: begin
            if (!rd_mark) begin
               state_in = srr_pkg::ST_FLUSH;
            end else if (slot_free) begin
               // another result follows, so the pending one is not last
               push      = 1'b1;
               pend_in   = dlv_res;
               wstart_in = wstart_ff + srr_pkg::WSTART_W'(1);
               state_in  = srr_pkg::ST_WREAD;
            end
         end
         srr_pkg::ST_FLUSH: begin
            if (slot_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = srr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (push) begin
         out_in       = pend_ff;
         out_last_in  = push_last;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srr_pkg::ST_CLEAR;
         wstart_ff    <= srr_pkg::WSTART_W'(srr_pkg::WSTART_RESET);
         ws_ff        <= srr_pkg::WS_W'(srr_pkg::WINDOW_RESET);
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wstart_ff    <= wstart_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            ws_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      seq_ff      <= seq_in;
      pay_ff      <= pay_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign wr_payload       = pay_ff;

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_kind  = out_ff.kind;
   assign rsp.result_seq   = out_ff.seq;
   assign rsp.ack_checksum = out_ff.ack_checksum;
   assign rsp.out_word0    = out_ff.word0;
   assign rsp.out_word1    = out_ff.word1;
   assign rsp.out_word2    = out_ff.word2;
   assign rsp.last_of_run  = out_last_ff;

endmodule

// ----- rtl/selective_repeat_receiver.sv -----
// channel | dir | handshake           | carries
// req     | in  | valid/ready         | one received packet
// rsp     | out | valid/ready         | ack, then in-order deliveries
// csr     | in  | csr_wr_en, no ready | window_size
//
// A request is checked the cycle after it is taken: a dropped one returns to idle, an
// ack-only answer passes through the flush state, and a new request walks the window
// until its end or an unmarked entry, each delivery reading the memories at the window
// start and using it. After reset a clearing pass writes the 1024 mark entries, one a
// cycle; no request is taken during that pass. A stalled rsp holds the walk; the next
// request is taken once the last result of the previous one sits in the output register.
module selective_repeat_receiver (
   input  logic                          clock,
   input  logic                          reset,
   srr_req_if.sink                       req,
   srr_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [srr_pkg::WS_W-1:0]      csr_wr_data
);

   logic                          cks_ok;
   logic                          csum_load;
   logic                          rd_mark;
   logic [srr_pkg::PAY_W-1:0]     rd_payload;
   logic [srr_pkg::PAY_W-1:0]     wr_payload;
   srr_pkg::store_cmd_type        cmd;

   srr_csum u_csum (
      .clock    (clock),
      .load     (csum_load),
      .seq      (req.received_seq),
      .ack      (req.received_ack),
      .checksum (req.received_checksum),
      .payload  ({req.payload_word2, req.payload_word1, req.payload_word0}),
      .ok       (cks_ok)
   );

   srr_store u_store (
      .clock      (clock),
      .cmd        (cmd),
      .wr_payload (wr_payload),
      .rd_mark    (rd_mark),
      .rd_payload (rd_payload)
   );

   srr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cks_ok      (cks_ok),
      .rd_mark     (rd_mark),
      .rd_payload  (rd_payload),
      .csum_load   (csum_load),
      .cmd         (cmd),
      .wr_payload  (wr_payload)
   );

endmodule
